[rtl/core/arrc_pkg.sv]
// Shared types and constants for the address range registry check block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package arrc_pkg;

	localparam int ADDR_W      = 64;
	localparam int SIZE_W      = 32;
	localparam int LABEL_TAG_W = 16;
	localparam int WINDOW_W    = 24;
	localparam int OP_W        = 2;
	localparam int VERDICT_W   = 2;

	localparam int MAX_RANGES_DEF = 128;
	localparam int LABEL_BITS_DEF = 16;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'h01_0000;

	localparam logic [OP_W-1:0] OP_CHECK      = 2'd0;
	localparam logic [OP_W-1:0] OP_REGISTER   = 2'd1;
	localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd2;

	localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN  = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_IN_RANGE = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_WALKED   = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic                 capture;
		logic                 clr_idx;
		logic                 inc_idx;
		logic                 rd_en;
		logic                 rd_next;
		logic                 wr_en;
		logic                 wr_at_cnt;
		logic                 wr_from_rd;
		logic                 cnt_inc;
		logic                 cnt_dec;
		logic                 cache_load;
		logic                 cache_inval;
		logic                 end_load;
		logic                 set_verdict;
		logic [VERDICT_W-1:0] verdict;
		logic                 set_changed;
		logic                 set_full;
		logic                 load_out;
	} arrc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic            addr_zero;
		logic            size_zero;
		logic            cache_hit;
		logic            scan_end;
		logic            shift_end;
		logic            tbl_full;
		logic            covers;
		logic            base_eq;
		logic            data_same;
		logic            walked;
	} arrc_sts_t;

endpackage

[rtl/core/arrc_if.sv]
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on arrc_pkg for field widths.
interface arrc_req_if import arrc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        opcode;
	logic [ADDR_W-1:0]      address;
	logic [SIZE_W-1:0]      range_size;
	logic [LABEL_TAG_W-1:0] label_tag;

	modport source (output valid, opcode, address, range_size, label_tag, input ready);
	modport sink   (input valid, opcode, address, range_size, label_tag, output ready);
endinterface

interface arrc_rsp_if import arrc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	logic                 table_changed;
	logic                 table_full;

	modport source (output valid, verdict, table_changed, table_full, input ready);
	modport sink   (input valid, verdict, table_changed, table_full, output ready);
endinterface

interface arrc_cfg_if import arrc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WINDOW_W-1:0] walk_past_window;

	modport source (output valid, walk_past_window, input ready);
	modport sink   (input valid, walk_past_window, output ready);
endinterface

[rtl/core/arrc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/arrc_ctrl.sv]
// Controller state machine: sequences capture, table scan, append/update,
// removal shift, walked-past test and response hand-off. Depends on arrc_pkg.
module arrc_ctrl import arrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  arrc_sts_t sts,
	output arrc_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_START    = 9'b000000010,
		ST_SCAN_RD  = 9'b000000100,
		ST_SCAN_CMP = 9'b000001000,
		ST_END      = 9'b000010000,
		ST_PAST     = 9'b000100000,
		ST_SHIFT_RD = 9'b001000000,
		ST_SHIFT_WR = 9'b010000000,
		ST_RESP     = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				cmd.clr_idx = 1'b1;
				state_d     = ST_SCAN_RD;
				case (sts.opcode)
					OP_CHECK: begin
						if (sts.addr_zero) begin
							state_d = ST_RESP;
						end else if (sts.cache_hit) begin
							cmd.set_verdict = 1'b1;
							cmd.verdict     = VERDICT_IN_RANGE;
							state_d         = ST_RESP;
						end
					end
					OP_REGISTER: begin
						if (sts.addr_zero || sts.size_zero) begin
							state_d = ST_RESP;
						end
					end
					OP_UNREGISTER: begin
						if (sts.addr_zero) begin
							state_d = ST_RESP;
						end
					end
					default: state_d = ST_RESP;
				endcase
			end
			ST_SCAN_RD: begin
				if (sts.scan_end) begin
					state_d = ST_RESP;
					case (sts.opcode)
						OP_CHECK: state_d = ST_END;
						OP_REGISTER: begin
							if (sts.tbl_full) begin
								cmd.set_full = 1'b1;
							end else begin
								cmd.wr_en       = 1'b1;
								cmd.wr_at_cnt   = 1'b1;
								cmd.cnt_inc     = 1'b1;
								cmd.cache_inval = 1'b1;
								cmd.set_changed = 1'b1;
							end
						end
						default: ;
					endcase
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				cmd.inc_idx = 1'b1;
				state_d     = ST_SCAN_RD;
				case (sts.opcode)
					OP_CHECK: begin
						if (sts.covers) begin
							cmd.cache_load  = 1'b1;
							cmd.set_verdict = 1'b1;
							cmd.verdict     = VERDICT_IN_RANGE;
							state_d         = ST_RESP;
						end
					end
					OP_REGISTER: begin
						if (sts.base_eq) begin
							state_d = ST_RESP;
							// same base: rewrite length and label only when they differ
							if (!sts.data_same) begin
								cmd.wr_en       = 1'b1;
								cmd.cache_inval = 1'b1;
								cmd.set_changed = 1'b1;
							end
						end
					end
					OP_UNREGISTER: begin
						if (sts.base_eq) begin
							cmd.inc_idx = 1'b0;
							state_d     = ST_SHIFT_RD;
						end
					end
					default: state_d = ST_RESP;
				endcase
			end
			ST_END: begin
				cmd.end_load = 1'b1;
				state_d      = ST_PAST;
			end
			ST_PAST: begin
				if (sts.walked) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = VERDICT_WALKED;
				end
				state_d = ST_RESP;
			end
			ST_SHIFT_RD: begin
				if (sts.shift_end) begin
					cmd.cnt_dec     = 1'b1;
					cmd.cache_inval = 1'b1;
					cmd.set_changed = 1'b1;
					state_d         = ST_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				// close the gap: entry idx+1 moves down to idx
				cmd.wr_en      = 1'b1;
				cmd.wr_from_rd = 1'b1;
				cmd.inc_idx    = 1'b1;
				state_d        = ST_SHIFT_RD;
			end
			ST_RESP: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

[rtl/core/arrc_dpath.sv]
// Datapath: request registers, table RAM, entry count, hit cache, window
// register, comparators and response registers. Depends on arrc_pkg, arrc_ram.
module arrc_dpath import arrc_pkg::*; #(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  arrc_cmd_t              cmd,
	output arrc_sts_t              sts,
	input  logic [OP_W-1:0]        opcode,
	input  logic [ADDR_W-1:0]      address,
	input  logic [SIZE_W-1:0]      range_size,
	input  logic [LABEL_TAG_W-1:0] label_tag,
	input  logic                   cfg_valid,
	input  logic [WINDOW_W-1:0]    walk_past_window,
	output logic [VERDICT_W-1:0]   verdict,
	output logic                   table_changed,
	output logic                   table_full
);

	localparam int IDX_W = $clog2(MAX_RANGES);
	localparam int CNT_W = $clog2(MAX_RANGES + 1);
	localparam int LBL_W = (LABEL_BITS < LABEL_TAG_W) ? LABEL_BITS : LABEL_TAG_W;
	localparam int ENT_W = ADDR_W + SIZE_W + LBL_W;

	logic [OP_W-1:0]      op_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [SIZE_W-1:0]    size_q;
	logic [LBL_W-1:0]     lbl_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 cache_valid_q;
	logic [ADDR_W-1:0]    cache_base_q;
	logic [SIZE_W-1:0]    cache_len_q;
	logic [WINDOW_W-1:0]  window_q;
	logic [ADDR_W:0]      end_q;
	logic [VERDICT_W-1:0] res_verdict_q;
	logic                 res_changed_q;
	logic                 res_full_q;
	logic [VERDICT_W-1:0] out_verdict_q;
	logic                 out_changed_q;
	logic                 out_full_q;

	logic [CNT_W-1:0]  idx_plus;
	logic [IDX_W-1:0]  raddr;
	logic [IDX_W-1:0]  waddr;
	logic [ENT_W-1:0]  wdata;
	logic [ENT_W-1:0]  rdata;
	logic [ADDR_W-1:0] rd_base;
	logic [SIZE_W-1:0] rd_len;
	logic [LBL_W-1:0]  rd_lbl;
	logic [ADDR_W-1:0] end_lo;

	assign idx_plus = idx_q + 1'b1;
	assign raddr    = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign waddr    = cmd.wr_at_cnt ? cnt_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign wdata    = cmd.wr_from_rd ? rdata : {addr_q, size_q, lbl_q};

	arrc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_base = rdata[ENT_W-1 -: ADDR_W];
	assign rd_len  = rdata[LBL_W +: SIZE_W];
	assign rd_lbl  = rdata[LBL_W-1:0];
	assign end_lo  = end_q[ADDR_W-1:0];

	always_comb begin
		sts           = '0;
		sts.opcode    = op_q;
		sts.addr_zero = (addr_q == '0);
		sts.size_zero = (size_q == '0);
		sts.cache_hit = cache_valid_q && (cache_len_q != '0) && (addr_q >= cache_base_q)
			&& ((addr_q - cache_base_q) < ADDR_W'(cache_len_q));
		sts.scan_end  = (idx_q == cnt_q);
		sts.shift_end = (idx_plus >= cnt_q);
		sts.tbl_full  = (cnt_q == CNT_W'(MAX_RANGES));
		sts.covers    = (addr_q >= rd_base) && ((addr_q - rd_base) < ADDR_W'(rd_len));
		sts.base_eq   = (rd_base == addr_q);
		sts.data_same = (rd_len == size_q) && (rd_lbl == lbl_q);
		// an end that carries past the top of the address space never matches
		sts.walked    = cache_valid_q && (cache_len_q != '0) && !end_q[ADDR_W]
			&& (addr_q >= end_lo) && ((addr_q - end_lo) < ADDR_W'(window_q));
	end

	// request and scratch registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			addr_q <= address;
			size_q <= range_size;
			lbl_q  <= label_tag[LBL_W-1:0];
		end
		if (cmd.end_load) begin
			end_q <= {1'b0, cache_base_q} + (ADDR_W + 1)'(cache_len_q);
		end
		if (cmd.capture) begin
			res_verdict_q <= VERDICT_UNKNOWN;
			res_changed_q <= 1'b0;
			res_full_q    <= 1'b0;
		end else begin
			if (cmd.set_verdict) begin
				res_verdict_q <= cmd.verdict;
			end
			if (cmd.set_changed) begin
				res_changed_q <= 1'b1;
			end
			if (cmd.set_full) begin
				res_full_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_verdict_q <= res_verdict_q;
			out_changed_q <= res_changed_q;
			out_full_q    <= res_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			cnt_q         <= '0;
			cache_valid_q <= 1'b0;
			cache_base_q  <= '0;
			cache_len_q   <= '0;
			window_q      <= WINDOW_RESET;
		end else begin
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_plus;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.cache_load) begin
				cache_valid_q <= 1'b1;
				cache_base_q  <= rd_base;
				cache_len_q   <= rd_len;
			end else if (cmd.cache_inval) begin
				cache_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				window_q <= walk_past_window;
			end
		end
	end

	assign verdict       = out_verdict_q;
	assign table_changed = out_changed_q;
	assign table_full    = out_full_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RANGES))
		else $error("entry count above table depth");

	a_update_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && !cmd.wr_at_cnt |-> idx_q < cnt_q)
		else $error("table write outside the filled entries");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && cmd.wr_at_cnt |-> cnt_q < CNT_W'(MAX_RANGES))
		else $error("append into a full table");

	a_cache_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cache_load |=> cache_valid_q && (cache_len_q != '0))
		else $error("cache loaded with an empty range");

	a_verdict_check_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && (res_verdict_q != VERDICT_UNKNOWN) |-> op_q == OP_CHECK)
		else $error("verdict reported for a non-check request");
`endif

endmodule

[rtl/core/address_range_registry_check_top.sv]
// Address range registry check: keeps an ordered table of up to MAX_RANGES
// ranges (base, length, label) in a single RAM and answers one response per
// request. A check with a zero address or a hit in the one-entry cache goes
// straight to the response, as does a register or an unregister with nothing
// to do and the unused opcode. Otherwise the table is scanned entry by entry
// (one registered RAM read, one compare) until the request stops at a match;
// a check that misses the whole table then runs the walked-past test, and a
// register that misses appends or is dropped. An unregister that removes
// entry i moves each later entry down one place, with a RAM read and then a
// RAM write for each entry moved. The next request is accepted while a
// response waits.
// Depends on arrc_pkg, arrc_if, arrc_ctrl, arrc_dpath and arrc_ram.
module address_range_registry_check_top import arrc_pkg::*; #(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	arrc_req_if.sink   req,
	arrc_rsp_if.source rsp,
	arrc_cfg_if.sink   cfg
);

	arrc_cmd_t cmd;
	arrc_sts_t sts;

	// the window register takes a write in any cycle
	assign cfg.ready = 1'b1;

	arrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arrc_dpath #(
		.MAX_RANGES(MAX_RANGES),
		.LABEL_BITS(LABEL_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (req.opcode),
		.address         (req.address),
		.range_size      (req.range_size),
		.label_tag       (req.label_tag),
		.cfg_valid       (cfg.valid),
		.walk_past_window(cfg.walk_past_window),
		.verdict         (rsp.verdict),
		.table_changed   (rsp.table_changed),
		.table_full      (rsp.table_full)
	);

endmodule

[verif/address_range_registry_check_top_test.sv]
// Testbench for the address range registry check block: drives requests and
// window writes over the valid/ready channels, predicts every response.
// Depends on arrc_pkg, arrc_if and address_range_registry_check_top.
`timescale 1ns / 1ps

import arrc_pkg::*;

class registry_scoreboard;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic                 changed;
		logic                 dropped;
	} reply_t;

	logic [ADDR_W-1:0]      entry_base[MAX_RANGES_DEF];
	logic [SIZE_W-1:0]      entry_length[MAX_RANGES_DEF];
	logic [LABEL_TAG_W-1:0] entry_label[MAX_RANGES_DEF];
	int                     entry_count;
	bit                     cache_valid;
	logic [ADDR_W-1:0]      cache_base;
	logic [SIZE_W-1:0]      cache_length;
	logic [WINDOW_W-1:0]    window;

	reply_t pending_replies[$];

	int mismatches;
	int requests;
	int checks;
	int in_range_hits;
	int walked_hits;
	int table_edits;
	int full_drops;
	int peak_count;
	int window_writes;

	function new();
		entry_count = 0;
		cache_valid = 1'b0;
		cache_base = '0;
		cache_length = '0;
		window = WINDOW_RESET;
	endfunction

	function bit covers(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] len,
			logic [ADDR_W-1:0] addr);
		return addr >= base && (addr - base) < {32'd0, len};
	endfunction

	function logic [VERDICT_W-1:0] lookup(logic [ADDR_W-1:0] addr);
		int i;
		logic [ADDR_W:0] range_end;
		if (addr == '0)
			return VERDICT_UNKNOWN;
		if (cache_valid && cache_length != '0 && covers(cache_base, cache_length, addr))
			return VERDICT_IN_RANGE;
		for (i = 0; i < entry_count; i++) begin
			if (covers(entry_base[i], entry_length[i], addr)) begin
				cache_valid = 1'b1;
				cache_base = entry_base[i];
				cache_length = entry_length[i];
				return VERDICT_IN_RANGE;
			end
		end
		if (cache_valid && cache_length != '0) begin
			// a carry out of the end sum means the range runs past the top
			range_end = {1'b0, cache_base} + {33'd0, cache_length};
			if (!range_end[ADDR_W] && addr >= range_end[ADDR_W-1:0] &&
					(addr - range_end[ADDR_W-1:0]) < {40'd0, window})
				return VERDICT_WALKED;
		end
		return VERDICT_UNKNOWN;
	endfunction

	function void enter_range(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] len,
			logic [LABEL_TAG_W-1:0] label, output bit changed, output bit dropped);
		int i;
		changed = 1'b0;
		dropped = 1'b0;
		if (base == '0 || len == '0)
			return;
		for (i = 0; i < entry_count; i++) begin
			if (entry_base[i] == base) begin
				if (entry_length[i] != len || entry_label[i] != label) begin
					entry_length[i] = len;
					entry_label[i] = label;
					cache_valid = 1'b0;
					changed = 1'b1;
				end
				return;
			end
		end
		if (entry_count >= MAX_RANGES_DEF) begin
			dropped = 1'b1;
			return;
		end
		entry_base[entry_count] = base;
		entry_length[entry_count] = len;
		entry_label[entry_count] = label;
		entry_count++;
		cache_valid = 1'b0;
		changed = 1'b1;
	endfunction

	function void remove_range(logic [ADDR_W-1:0] base, output bit changed);
		int i;
		int j;
		changed = 1'b0;
		if (base == '0)
			return;
		for (i = 0; i < entry_count; i++) begin
			if (entry_base[i] == base) begin
				// close the gap
				for (j = i; j + 1 < entry_count; j++) begin
					entry_base[j] = entry_base[j + 1];
					entry_length[j] = entry_length[j + 1];
					entry_label[j] = entry_label[j + 1];
				end
				entry_count--;
				cache_valid = 1'b0;
				changed = 1'b1;
				return;
			end
		end
	endfunction

	function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
			logic [SIZE_W-1:0] len, logic [LABEL_TAG_W-1:0] label);
		reply_t want;
		bit changed;
		bit dropped;
		want = '0;
		changed = 1'b0;
		dropped = 1'b0;
		case (op)
			OP_CHECK: begin
				want.verdict = lookup(addr);
				checks++;
				if (want.verdict == VERDICT_IN_RANGE)
					in_range_hits++;
				if (want.verdict == VERDICT_WALKED)
					walked_hits++;
			end
			OP_REGISTER: enter_range(addr, len, label, changed, dropped);
			OP_UNREGISTER: remove_range(addr, changed);
			default: ;
		endcase
		want.changed = changed;
		want.dropped = dropped;
		pending_replies = {pending_replies, want};
		requests++;
		table_edits += changed;
		full_drops += dropped;
		if (entry_count > peak_count)
			peak_count = entry_count;
	endfunction

	function void check_reply(logic [VERDICT_W-1:0] verdict, logic changed, logic dropped);
		reply_t want;
		if (pending_replies.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: response with none pending: verdict %0d changed %0b full %0b",
					$time, verdict, changed, dropped);
			return;
		end
		want = pending_replies.pop_front();
		if (want.verdict !== verdict || want.changed !== changed || want.dropped !== dropped) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: response mismatch: verdict %0d/%0d changed %0b/%0b full %0b/%0b",
					$time, want.verdict, verdict, want.changed, changed,
					want.dropped, dropped);
		end
	endfunction

endclass

module address_range_registry_check_top_test;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int POOL_SIZE = 48;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	arrc_req_if req ();
	arrc_rsp_if rsp ();
	arrc_cfg_if cfg ();

	address_range_registry_check_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	registry_scoreboard sb;

	logic [ADDR_W-1:0] base_pool[POOL_SIZE];
	int  gap_pct;
	int  stall_pct;
	bit  quiet;
	int  hold_request;
	int  hold_left;
	int  stall_left;
	longint cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Response side: random stall bursts, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp.ready = 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 10);
			rsp.ready = 1'b0;
		end else begin
			rsp.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_reply(rsp.verdict, rsp.table_changed, rsp.table_full);
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [SIZE_W-1:0] rand_length();
		case ($urandom_range(0, 9))
			0: return 32'd1;
			1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			3: return $urandom;
			default: return $urandom_range(1, 32'h3000);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so back-to-back requests keep it up.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [SIZE_W-1:0] len, input logic [LABEL_TAG_W-1:0] label);
		int gap;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 11);
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.opcode = op;
		req.address = addr;
		req.range_size = len;
		req.label_tag = label;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, addr, len, label);
		@(negedge clk);
	endtask

	task automatic drain_requests();
		req.valid = 1'b0;
		while (sb.pending_replies.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_window(input logic [WINDOW_W-1:0] value);
		cfg.walk_past_window = value;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		sb.window = value;
		sb.window_writes++;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic send_random_request();
		int r;
		int s;
		int idx;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] anchor;
		logic [SIZE_W-1:0] len;
		logic [LABEL_TAG_W-1:0] lbl;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 19);
		idx = sb.entry_count > 0 ? $urandom_range(0, sb.entry_count - 1) : -1;
		len = rand_length();
		lbl = $urandom;
		if (r < 55) begin
			if (s == 0)
				a = '0;
			else if (s < 7 && idx >= 0)
				a = sb.entry_base[idx] + ($urandom % sb.entry_length[idx]);
			else if (s < 11 && (sb.cache_valid || idx >= 0)) begin
				// aim just past the end of the cached range or some entry
				if (sb.cache_valid)
					anchor = sb.cache_base + sb.cache_length;
				else
					anchor = sb.entry_base[idx] + sb.entry_length[idx];
				a = anchor + ($urandom % ({8'd0, sb.window} + 32'd16));
			end else if (s < 13)
				a = base_pool[$urandom_range(0, POOL_SIZE - 1)] + $urandom_range(0, 32'h3000);
			else if (s == 13)
				a = ~64'd0 - $urandom_range(0, 3);
			else
				a = rand_addr();
			send_request(OP_CHECK, a, $urandom, lbl);
		end else if (r < 80) begin
			if (s < 10)
				a = base_pool[$urandom_range(0, POOL_SIZE - 1)];
			else if (s < 14 && idx >= 0) begin
				a = sb.entry_base[idx];
				len = sb.entry_length[idx];
				lbl = sb.entry_label[idx];
			end else if (s < 16 && idx >= 0)
				a = sb.entry_base[idx];
			else if (s == 16)
				a = '0;
			else if (sb.entry_count < 96)
				a = rand_addr();
			else
				a = base_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_request(OP_REGISTER, a, len, lbl);
		end else if (r < 95) begin
			if (s < 14 && idx >= 0)
				a = sb.entry_base[idx];
			else if (s < 17)
				a = base_pool[$urandom_range(0, POOL_SIZE - 1)];
			else if (s < 19)
				a = rand_addr();
			else
				a = '0;
			send_request(OP_UNREGISTER, a, len, lbl);
		end else begin
			send_request(OP_UNUSED, rand_addr(), $urandom, lbl);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] cluster;
		logic [ADDR_W-1:0] a;
		int idx;
		int k;

		sb = new();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = OP_CHECK;
		req.address = '0;
		req.range_size = '0;
		req.label_tag = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.walk_past_window = '0;
		quiet = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		hold_request = 0;

		// Overlapping cluster, bases near the top, low bases, scattered bases.
		cluster = (rand_addr() & 64'h00FF_FFFF_FFFF_0000) | 64'h1_0000;
		for (k = 0; k < POOL_SIZE; k++) begin
			if (k < 16)
				base_pool[k] = cluster + k * 64'h800;
			else if (k < 24)
				base_pool[k] = 64'hFFFF_FFFF_FFFF_0000 | $urandom_range(0, 16'hFFFF);
			else if (k < 32)
				base_pool[k] = $urandom_range(1, 32'h10_0000);
			else
				base_pool[k] = rand_addr() | 64'd1;
		end

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, reset window.
		send_request(OP_CHECK, 64'd0, 32'd0, 16'd0);
		send_request(OP_CHECK, 64'h1000, 32'd0, 16'd0);
		send_request(OP_REGISTER, 64'd0, 32'd16, 16'h1);
		send_request(OP_REGISTER, 64'h1000, 32'd0, 16'h1);
		send_request(OP_REGISTER, 64'h1000, 32'h100, 16'hFFFF);
		send_request(OP_REGISTER, 64'h1000, 32'h100, 16'hFFFF);
		send_request(OP_REGISTER, 64'h1000, 32'h200, 16'hFFFF);
		send_request(OP_REGISTER, 64'h1080, 32'h10, 16'h0);
		send_request(OP_CHECK, 64'h1090, 32'd0, 16'd0);
		send_request(OP_CHECK, 64'h1200 + 64'hFFFF, 32'd0, 16'd0);
		send_request(OP_CHECK, 64'h1200 + 64'h10000, 32'd0, 16'd0);
		send_request(OP_CHECK, 64'd0, 32'd0, 16'd0);
		send_request(OP_CHECK, 64'h1201, 32'd0, 16'd0);
		send_request(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 16'h1234);
		send_request(OP_CHECK, ~64'd0, 32'd0, 16'd0);
		send_request(OP_CHECK, 64'h1300, 32'd0, 16'd0);
		send_request(OP_UNREGISTER, 64'h5555, 32'd0, 16'd0);
		send_request(OP_UNREGISTER, 64'd0, 32'd0, 16'd0);
		send_request(OP_UNUSED, ~64'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_UNREGISTER, 64'h1000, 32'd0, 16'd0);
		send_request(OP_CHECK, 64'h1085, 32'd0, 16'd0);
		send_request(OP_REGISTER, ~64'd0, 32'd1, 16'hAAAA);
		send_request(OP_CHECK, 64'h1095, 32'd0, 16'd0);
		send_request(OP_CHECK, ~64'd0, 32'd0, 16'd0);
		drain_requests();

		// Widest window.
		write_window(24'hFF_FFFF);
		gap_pct = 30;
		stall_pct = 30;
		repeat (300) send_random_request();
		drain_requests();

		// Zero window; open with a long response hold-off to back the block up.
		write_window(24'd0);
		gap_pct = 0;
		hold_request = 300;
		repeat (30) send_random_request();
		gap_pct = 30;
		repeat (270) send_random_request();
		drain_requests();

		write_window(24'd1);
		gap_pct = 50;
		stall_pct = 50;
		repeat (300) send_random_request();
		drain_requests();

		// Fill the table to capacity, overflow it, then empty most of it.
		write_window($urandom_range(2, 24'hFF_FFFF));
		gap_pct = 20;
		stall_pct = 20;
		k = 0;
		while (sb.entry_count < MAX_RANGES_DEF) begin
			do a = rand_addr(); while (a == '0);
			send_request(OP_REGISTER, a, $urandom_range(1, 32'hFFFF), $urandom);
			if (++k % 6 == 0)
				send_random_request();
		end
		repeat (4) begin
			do a = rand_addr(); while (a == '0);
			send_request(OP_REGISTER, a, rand_length() | 32'd1, $urandom);
		end
		idx = $urandom_range(0, MAX_RANGES_DEF - 1);
		send_request(OP_REGISTER, sb.entry_base[idx], sb.entry_length[idx] + 32'd1, $urandom);
		repeat (30) send_random_request();
		k = 0;
		while (sb.entry_count > 8) begin
			idx = $urandom_range(0, sb.entry_count - 1);
			send_request(OP_UNREGISTER, sb.entry_base[idx], $urandom, $urandom);
			if (++k % 5 == 0)
				send_random_request();
		end
		drain_requests();

		// Last part: reset-value window, no idling on either side.
		write_window(WINDOW_RESET);
		quiet = 1'b1;
		repeat (300) send_random_request();
		drain_requests();
		repeat (20) @(negedge clk);

		$display("Covered %0d requests: %0d checks (%0d in range, %0d walked past), %0d edits",
			sb.requests, sb.checks, sb.in_range_hits, sb.walked_hits, sb.table_edits);
		$display("Table peak %0d entries, %0d full drops, %0d window writes, %0d mismatches",
			sb.peak_count, sb.full_drops, sb.window_writes, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
